// ----- rtl/gds_pkg.sv -----
// Shared types, constants and calendar helper functions for the date stepper.
`default_nettype none
package gds_pkg;

  localparam int DayW   = 5;
  localparam int MonW   = 4;
  localparam int YearW  = 14;
  localparam int CountW = 16;
  localparam int WdayW  = 3;
  localparam int DoyW   = 9;
  localparam int WeekW  = 6;
  localparam int QtrW   = 3;
  localparam int SumW   = 16;
  localparam int Q100W  = 8;

  // Command codes carried on the command bit of an input beat.
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdAdd  = 1'b1;

  localparam logic [DayW-1:0]  ResetDay   = DayW'(1);
  localparam logic [MonW-1:0]  ResetMonth = MonW'(1);
  localparam logic [YearW-1:0] ResetYear  = YearW'(1900);
  localparam logic [YearW-1:0] MinYear    = YearW'(1);
  localparam logic [YearW-1:0] MaxYear    = YearW'(9999);
  localparam logic [MonW-1:0]  January    = MonW'(1);
  localparam logic [MonW-1:0]  February   = MonW'(2);
  localparam logic [MonW-1:0]  December   = MonW'(12);

  // Reciprocal constants: exact for the value ranges used here.
  localparam int Div100Mul   = 5243;
  localparam int Div100Shift = 19;
  localparam int Div7Mul     = 18725;
  localparam int Div7Shift   = 17;

  // Day, month and offset terms of the weekday sum for January 1 (month 13).
  localparam logic [SumW-1:0] JanTerm = SumW'(36);

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_TAKE_LOAD,
    DP_TAKE_ADD,
    DP_DIV,
    DP_LEAP,
    DP_STEP,
    DP_COMMIT,
    DP_RESTORE,
    DP_SUM,
    DP_MOD,
    DP_PUSH
  } gds_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP_A,
    S_LEAP_B,
    S_CHECK,
    S_WALK,
    S_DIV,
    S_SUM,
    S_MOD,
    S_PUSH
  } gds_state_t;

  typedef struct packed {
    logic load_ok;
    logic rem_zero;
    logic step_roll;
    logic step_oob;
    logic out_busy;
  } gds_stat_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    if (m == February) begin
      len = leap ? DayW'(29) : DayW'(28);
    end else if (m < MonW'(8)) begin
      len = m[0] ? DayW'(31) : DayW'(30);
    end else begin
      len = m[0] ? DayW'(30) : DayW'(31);
    end
    return len;
  endfunction

  function automatic logic [Q100W-1:0] div100(input logic [YearW-1:0] y);
    logic [YearW+12:0] p;
    p = {13'b0, y} * (YearW+13)'(Div100Mul);
    return p[Div100Shift +: Q100W];
  endfunction

  // y is a leap year; q is y / 100
  function automatic logic leap_of(input logic [YearW-1:0] y, input logic [Q100W-1:0] q);
    logic [YearW-1:0] r;
    r = y - YearW'(q * YearW'(100));
    return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [SumW-1:0] div7(input logic [SumW-1:0] x);
    logic [2*SumW:0] p;
    p = {17'b0, x} * (2*SumW+1)'(Div7Mul);
    return SumW'(p >> Div7Shift);
  endfunction

  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] x);
    logic [SumW-1:0] q;
    q = div7(x);
    return WdayW'(x - SumW'(q * SumW'(7)));
  endfunction

  // 3 * (m + 1) / 5 for months 3..14
  function automatic logic [3:0] wd_term(input logic [MonW:0] m);
    logic [3:0] t;
    unique case (m)
      5'd3:           t = 4'd2;
      5'd4, 5'd5:     t = 4'd3;
      5'd6, 5'd7:     t = 4'd4;
      5'd8:           t = 4'd5;
      5'd9, 5'd10:    t = 4'd6;
      5'd11, 5'd12:   t = 4'd7;
      5'd13:          t = 4'd8;
      5'd14:          t = 4'd9;
      default:        t = 4'd0;
    endcase
    return t;
  endfunction

  // days in a common year before the first of month m
  function automatic logic [DoyW-1:0] days_before(input logic [MonW-1:0] m);
    logic [DoyW-1:0] d;
    unique case (m)
      4'd2:    d = DoyW'(31);
      4'd3:    d = DoyW'(59);
      4'd4:    d = DoyW'(90);
      4'd5:    d = DoyW'(120);
      4'd6:    d = DoyW'(151);
      4'd7:    d = DoyW'(181);
      4'd8:    d = DoyW'(212);
      4'd9:    d = DoyW'(243);
      4'd10:   d = DoyW'(273);
      4'd11:   d = DoyW'(304);
      4'd12:   d = DoyW'(334);
      default: d = DoyW'(0);
    endcase
    return d;
  endfunction

  function automatic logic [QtrW-1:0] quarter_of(input logic [MonW-1:0] m);
    logic [QtrW-1:0] q;
    priority if (m <= MonW'(3)) begin
      q = QtrW'(1);
    end else if (m <= MonW'(6)) begin
      q = QtrW'(2);
    end else if (m <= MonW'(9)) begin
      q = QtrW'(3);
    end else begin
      q = QtrW'(4);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gds_chan_if.sv -----
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none
interface gds_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [gds_pkg::DayW-1:0]          load_day;
  logic [gds_pkg::MonW-1:0]          load_month;
  logic [gds_pkg::YearW-1:0]         load_year;
  logic signed [gds_pkg::CountW-1:0] day_count;

  modport source(output valid, command, load_day, load_month, load_year, day_count,
                 input ready);
  modport sink(input valid, command, load_day, load_month, load_year, day_count,
               output ready);
endinterface

interface gds_out_if;
  logic                        valid;
  logic                        ready;
  logic [gds_pkg::DayW-1:0]    out_day;
  logic [gds_pkg::MonW-1:0]    out_month;
  logic [gds_pkg::YearW-1:0]   out_year;
  logic [gds_pkg::WdayW-1:0]   weekday;
  logic [gds_pkg::DoyW-1:0]    day_of_year;
  logic [gds_pkg::WeekW-1:0]   week_of_year;
  logic [gds_pkg::QtrW-1:0]    quarter;
  logic                        is_leap;
  logic                        rejected;

  modport source(output valid, out_day, out_month, out_year, weekday, day_of_year,
                 week_of_year, quarter, is_leap, rejected, input ready);
  modport sink(input valid, out_day, out_month, out_year, weekday, day_of_year,
               week_of_year, quarter, is_leap, rejected, output ready);
endinterface
`default_nettype wire

// ----- rtl/gds_ctrl.sv -----
// Sequencer: takes command beats and steps the datapath through load, walk and report.
`default_nettype none
module gds_ctrl (
  input  logic               clk,
  input  logic               rst,
  gds_in_if.sink             item,
  input  gds_pkg::gds_stat_t stat,
  output gds_pkg::gds_op_t   op
);

  gds_pkg::gds_state_t state;
  gds_pkg::gds_state_t state_next;
  logic                is_add;
  logic                is_add_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gds_pkg::S_IDLE;
      is_add <= 1'b0;
    end else begin
      state  <= state_next;
      is_add <= is_add_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    is_add_next = is_add;
    unique case (state)
      gds_pkg::S_IDLE: begin
        if (item.valid) begin
          state_next  = gds_pkg::S_LEAP_A;
          is_add_next = (item.command == gds_pkg::CmdAdd);
        end
      end
      gds_pkg::S_LEAP_A: state_next = gds_pkg::S_LEAP_B;
      gds_pkg::S_LEAP_B: state_next = is_add ? gds_pkg::S_WALK : gds_pkg::S_CHECK;
      gds_pkg::S_CHECK:  state_next = gds_pkg::S_DIV;
      gds_pkg::S_WALK: begin
        priority if (stat.rem_zero || stat.step_oob) begin
          state_next = gds_pkg::S_DIV;
        end else if (stat.step_roll) begin
          state_next = gds_pkg::S_LEAP_A;
        end else begin
          state_next = gds_pkg::S_WALK;
        end
      end
      gds_pkg::S_DIV:  state_next = gds_pkg::S_SUM;
      gds_pkg::S_SUM:  state_next = gds_pkg::S_MOD;
      gds_pkg::S_MOD:  state_next = gds_pkg::S_PUSH;
      gds_pkg::S_PUSH: begin
        if (!stat.out_busy) begin
          state_next = gds_pkg::S_IDLE;
        end
      end
      default: state_next = gds_pkg::S_IDLE;
    endcase
  end

  // outputs; no beat is taken while reset is held
  always_comb begin
    op         = gds_pkg::DP_IDLE;
    item.ready = 1'b0;
    unique case (state)
      gds_pkg::S_IDLE: begin
        item.ready = !rst;
        if (item.valid && !rst) begin
          op = (item.command == gds_pkg::CmdAdd) ? gds_pkg::DP_TAKE_ADD
                                                 : gds_pkg::DP_TAKE_LOAD;
        end
      end
      gds_pkg::S_LEAP_A: op = gds_pkg::DP_DIV;
      gds_pkg::S_LEAP_B: op = gds_pkg::DP_LEAP;
      gds_pkg::S_CHECK:  op = stat.load_ok ? gds_pkg::DP_COMMIT : gds_pkg::DP_RESTORE;
      gds_pkg::S_WALK: begin
        priority if (stat.rem_zero) begin
          op = gds_pkg::DP_COMMIT;
        end else if (stat.step_oob) begin
          op = gds_pkg::DP_RESTORE;
        end else begin
          op = gds_pkg::DP_STEP;
        end
      end
      gds_pkg::S_DIV:  op = gds_pkg::DP_DIV;
      gds_pkg::S_SUM:  op = gds_pkg::DP_SUM;
      gds_pkg::S_MOD:  op = gds_pkg::DP_MOD;
      gds_pkg::S_PUSH: op = stat.out_busy ? gds_pkg::DP_IDLE : gds_pkg::DP_PUSH;
      default:         op = gds_pkg::DP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/gds_datapath.sv -----
// Date registers, month walker, leap and weekday arithmetic, and the result register.
`default_nettype none
module gds_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  gds_pkg::gds_op_t                  op,
  output gds_pkg::gds_stat_t                stat,
  input  logic [gds_pkg::DayW-1:0]          load_day,
  input  logic [gds_pkg::MonW-1:0]          load_month,
  input  logic [gds_pkg::YearW-1:0]         load_year,
  input  logic signed [gds_pkg::CountW-1:0] day_count,
  gds_out_if.source                         result
);

  // committed date
  logic [gds_pkg::DayW-1:0]          cday;
  logic [gds_pkg::MonW-1:0]          cmonth;
  logic [gds_pkg::YearW-1:0]         cyear;
  // working date
  logic [gds_pkg::DayW-1:0]          wday;
  logic [gds_pkg::MonW-1:0]          wmonth;
  logic [gds_pkg::YearW-1:0]         wyear;
  logic signed [gds_pkg::CountW-1:0] rem;
  logic [gds_pkg::Q100W-1:0]         q100;
  logic [gds_pkg::Q100W-1:0]         qm1;
  logic                              wleap;
  logic                              rej;
  logic [gds_pkg::SumW-1:0]          sum_day;
  logic [gds_pkg::SumW-1:0]          sum_jan;
  logic [gds_pkg::WdayW-1:0]         wkday;
  logic [gds_pkg::WdayW-1:0]         jan1;
  logic [gds_pkg::DoyW-1:0]          doy;
  logic                              ovalid;

  logic [gds_pkg::DayW-1:0]   mlen;
  logic [gds_pkg::DayW-1:0]   d_left;
  logic [gds_pkg::MonW-1:0]   prev_month;
  logic [gds_pkg::DayW-1:0]   prev_len;
  logic                       neg;
  logic [gds_pkg::CountW:0]   nmag;
  logic                       fwd_fits;
  logic                       back_fits;
  logic                       roll;
  logic [gds_pkg::YearW-1:0]  ym1;
  logic                       early;
  logic [gds_pkg::YearW-1:0]  yy;
  logic [gds_pkg::Q100W-1:0]  qq;
  logic [gds_pkg::MonW:0]     mm;
  logic [gds_pkg::SumW-1:0]   wk_idx;
  logic [gds_pkg::SumW-1:0]   wk_q;

  assign mlen       = gds_pkg::month_len(wmonth, wleap);
  assign d_left     = mlen - wday;
  assign prev_month = (wmonth == gds_pkg::January) ? gds_pkg::December
                                                   : wmonth - gds_pkg::MonW'(1);
  assign prev_len   = gds_pkg::month_len(prev_month, wleap);
  assign neg        = rem[gds_pkg::CountW-1];
  assign nmag       = (gds_pkg::CountW+1)'(-$signed({rem[gds_pkg::CountW-1], rem}));
  assign fwd_fits   = !neg && (gds_pkg::CountW'(rem) <= gds_pkg::CountW'(d_left));
  assign back_fits  = nmag < (gds_pkg::CountW+1)'(wday);
  assign roll       = neg ? (!back_fits && wmonth == gds_pkg::January)
                          : (!fwd_fits && wmonth == gds_pkg::December);

  assign stat.rem_zero  = (rem == '0);
  assign stat.step_roll = roll;
  assign stat.step_oob  = roll && (neg ? (wyear == gds_pkg::MinYear)
                                       : (wyear == gds_pkg::MaxYear));
  assign stat.load_ok   = (wyear >= gds_pkg::MinYear) && (wyear <= gds_pkg::MaxYear) &&
                          (wmonth >= gds_pkg::January) && (wmonth <= gds_pkg::December) &&
                          (wday != '0) && (wday <= mlen);
  assign stat.out_busy  = ovalid && !result.ready;

  // January and February count as months 13 and 14 of the year before
  assign ym1   = wyear - gds_pkg::YearW'(1);
  assign early = (wmonth <= gds_pkg::February);
  assign yy    = early ? ym1 : wyear;
  assign qq    = early ? qm1 : q100;
  assign mm    = early ? ({1'b0, wmonth} + (gds_pkg::MonW+1)'(12)) : {1'b0, wmonth};

  assign wk_idx = gds_pkg::SumW'(doy) - gds_pkg::SumW'(1) + gds_pkg::SumW'(jan1);
  assign wk_q   = gds_pkg::div7(wk_idx);

  // committed date
  always_ff @(posedge clk) begin
    if (rst) begin
      cday   <= gds_pkg::ResetDay;
      cmonth <= gds_pkg::ResetMonth;
      cyear  <= gds_pkg::ResetYear;
    end else if (op == gds_pkg::DP_COMMIT) begin
      cday   <= wday;
      cmonth <= wmonth;
      cyear  <= wyear;
    end
  end

  // working date and arithmetic
  always_ff @(posedge clk) begin
    unique case (op)
      gds_pkg::DP_TAKE_LOAD: begin
        wday   <= load_day;
        wmonth <= load_month;
        wyear  <= load_year;
        rem    <= '0;
        rej    <= 1'b0;
      end
      gds_pkg::DP_TAKE_ADD: begin
        wday   <= cday;
        wmonth <= cmonth;
        wyear  <= cyear;
        rem    <= day_count;
        rej    <= 1'b0;
      end
      gds_pkg::DP_DIV: begin
        q100 <= gds_pkg::div100(wyear);
        qm1  <= gds_pkg::div100(ym1);
      end
      gds_pkg::DP_LEAP: wleap <= gds_pkg::leap_of(wyear, q100);
      gds_pkg::DP_STEP: begin
        if (!neg) begin
          if (fwd_fits) begin
            wday <= wday + gds_pkg::DayW'(rem);
            rem  <= '0;
          end else begin
            rem  <= rem - $signed(gds_pkg::CountW'(d_left)) - gds_pkg::CountW'(1);
            wday <= gds_pkg::DayW'(1);
            if (wmonth == gds_pkg::December) begin
              wmonth <= gds_pkg::January;
              wyear  <= wyear + gds_pkg::YearW'(1);
            end else begin
              wmonth <= wmonth + gds_pkg::MonW'(1);
            end
          end
        end else begin
          if (back_fits) begin
            wday <= wday - gds_pkg::DayW'(nmag);
            rem  <= '0;
          end else begin
            rem    <= rem + $signed(gds_pkg::CountW'(wday));
            wday   <= prev_len;
            wmonth <= prev_month;
            if (wmonth == gds_pkg::January) begin
              wyear <= ym1;
            end
          end
        end
      end
      gds_pkg::DP_RESTORE: begin
        wday   <= cday;
        wmonth <= cmonth;
        wyear  <= cyear;
        rem    <= '0;
        rej    <= 1'b1;
      end
      gds_pkg::DP_SUM: begin
        wleap   <= gds_pkg::leap_of(wyear, q100);
        sum_day <= gds_pkg::SumW'(wday) + gds_pkg::SumW'({mm, 1'b0}) +
                   gds_pkg::SumW'(gds_pkg::wd_term(mm)) + gds_pkg::SumW'(yy) +
                   gds_pkg::SumW'(yy >> 2) - gds_pkg::SumW'(qq) +
                   gds_pkg::SumW'(qq >> 2) + gds_pkg::SumW'(1);
        sum_jan <= gds_pkg::SumW'(ym1) + gds_pkg::SumW'(ym1 >> 2) - gds_pkg::SumW'(qm1) +
                   gds_pkg::SumW'(qm1 >> 2) + gds_pkg::JanTerm;
      end
      gds_pkg::DP_MOD: begin
        wkday <= gds_pkg::mod7(sum_day);
        jan1  <= gds_pkg::mod7(sum_jan);
        doy   <= gds_pkg::days_before(wmonth) + gds_pkg::DoyW'(wday) +
                 gds_pkg::DoyW'(wleap && (wmonth > gds_pkg::February));
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (op == gds_pkg::DP_PUSH) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == gds_pkg::DP_PUSH) begin
      result.out_day      <= cday;
      result.out_month    <= cmonth;
      result.out_year     <= cyear;
      result.weekday      <= wkday;
      result.day_of_year  <= doy;
      result.week_of_year <= gds_pkg::WeekW'(wk_q + gds_pkg::SumW'(1));
      result.quarter      <= gds_pkg::quarter_of(cmonth);
      result.is_leap      <= wleap;
      result.rejected     <= rej;
    end
  end

  assign result.valid = ovalid;

`ifndef SYNTHESIS
  a_cur_date_valid: assert property (@(posedge clk) disable iff (rst)
    (cmonth >= gds_pkg::January) && (cmonth <= gds_pkg::December) && (cday != '0) &&
    (cyear >= gds_pkg::MinYear) && (cyear <= gds_pkg::MaxYear))
    else $error("committed date out of range");

  a_restore_copies: assert property (@(posedge clk) disable iff (rst)
    (op == gds_pkg::DP_RESTORE) |=> (wday == cday) && (wmonth == cmonth) && (wyear == cyear))
    else $error("restore did not return working date to committed date");

  a_fwd_walk_sign: assert property (@(posedge clk) disable iff (rst)
    (op == gds_pkg::DP_STEP) && !rem[gds_pkg::CountW-1] |=> !rem[gds_pkg::CountW-1])
    else $error("forward walk overshot the day count");
`endif

endmodule
`default_nettype wire

// ----- rtl/gregorian_date_stepper.sv -----
// Top level of the Gregorian date stepper: sequencer plus datapath.
`default_nettype none
// Holds one Gregorian date (reset: 1900-01-01). Each command beat yields exactly one
// result beat. command 0 loads load_day/load_month/load_year if it is a real date in
// years 1..9999, else the date stays and rejected is set. command 1 adds the signed
// day_count; if the result would leave 0001-01-01..9999-12-31 the date stays and
// rejected is set. Every result carries the current date with weekday (0 = Sunday),
// day of year, Sunday-started week number, quarter and leap flag. The block takes one
// beat at a time. An add walks one month per cycle through a month-length compare and
// subtract, pausing at each year crossed to recompute the leap flag. The next beat can
// be taken in the same cycle as the result goes valid. The result sits in an output
// register; the next command is accepted while it waits, and the block stalls only
// when a new result is ready and the old one has not been taken. No beat is taken
// while rst is high.
module gregorian_date_stepper (
  input  logic       clk,
  input  logic       rst,
  gds_in_if.sink     item,
  gds_out_if.source  result
);

  gds_pkg::gds_op_t   op;    // datapath command from the sequencer
  gds_pkg::gds_stat_t stat;  // walk and check status back to the sequencer

  gds_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .stat (stat),
    .op   (op)
  );

  gds_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .stat       (stat),
    .load_day   (item.load_day),
    .load_month (item.load_month),
    .load_year  (item.load_year),
    .day_count  (item.day_count),
    .result     (result)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the Gregorian date stepper: directed table, then random beats.
`timescale 1ns / 100ps

module testbench;

  localparam int RandomBeats  = 500;
  localparam int IdlePercent  = 16;
  localparam int SettleCycles = 1400;

  // One result beat as the block reports it.
  typedef struct packed {
    logic [gds_pkg::DayW-1:0]  day;
    logic [gds_pkg::MonW-1:0]  month;
    logic [gds_pkg::YearW-1:0] year;
    logic [gds_pkg::WdayW-1:0] wday;
    logic [gds_pkg::DoyW-1:0]  doy;
    logic [gds_pkg::WeekW-1:0] week;
    logic [gds_pkg::QtrW-1:0]  qtr;
    logic                      leap;
    logic                      rej;
  } date_rpt_t;

  // One row of the directed table. When pinned is set, want is the typed-in result.
  typedef struct {
    logic                              cmd;
    logic [gds_pkg::DayW-1:0]          day;
    logic [gds_pkg::MonW-1:0]          month;
    logic [gds_pkg::YearW-1:0]         year;
    logic signed [gds_pkg::CountW-1:0] count;
    bit                                pinned;
    date_rpt_t                         want;
  } plan_row_t;

  // Results that can be read straight off the calendar.
  // 1900-01-01 is a Monday in a common year.
  localparam date_rpt_t ResetRpt = '{day: 5'd1, month: 4'd1, year: 14'd1900, wday: 3'd1,
                                     doy: 9'd1, week: 6'd1, qtr: 3'd1, leap: 1'b0,
                                     rej: 1'b0};
  // 9999-12-31 is a Friday; Jan 1 of 9999 is also a Friday, so it sits in week 53.
  localparam date_rpt_t LastDayRpt = '{day: 5'd31, month: 4'd12, year: 14'd9999, wday: 3'd5,
                                       doy: 9'd365, week: 6'd53, qtr: 3'd4, leap: 1'b0,
                                       rej: 1'b0};
  // 0001-01-01 is a Monday (proleptic Gregorian).
  localparam date_rpt_t FirstDayRpt = '{day: 5'd1, month: 4'd1, year: 14'd1, wday: 3'd1,
                                        doy: 9'd1, week: 6'd1, qtr: 3'd1, leap: 1'b0,
                                        rej: 1'b0};

  logic clk = 1'b0;
  logic rst;

  gds_in_if  cmd_bus ();
  gds_out_if date_bus ();

  gregorian_date_stepper uut (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd_bus),
    .result (date_bus)
  );

  always #2 clk = ~clk;

  // Calendar state of the predictor.
  int cal_day;
  int cal_month;
  int cal_year;

  date_rpt_t dates_due[$];   // predicted result beats, oldest first
  plan_row_t plan[$];        // directed table
  int        mismatches = 0;
  bit        steady_run = 1'b0;  // both sides hold off idling while set

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit has_feb29(int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int month_days(int m, int y);
    int len;
    case (m)
      2:             len = has_feb29(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // Serial day number of Jan 1 of year y, counted from 0001-01-01 = 0.
  function automatic int days_to_jan1(int y);
    int p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic int year_day(int d, int m, int y);
    int n;
    n = d;
    for (int i = 1; i < m; i++) n += month_days(i, y);
    return n;
  endfunction

  // Weekday sum, 0 = Sunday; Jan and Feb count as months 13/14 of the prior year.
  function automatic int day_of_week(int d, int m, int y);
    if (m <= 2) begin
      m += 12;
      y -= 1;
    end
    return (d + 2 * m + 3 * (m + 1) / 5 + y + y / 4 - y / 100 + y / 400 + 1) % 7;
  endfunction

  // Apply one command beat to the predicted calendar and return the result beat.
  function automatic date_rpt_t step_calendar(logic cmd, logic [gds_pkg::DayW-1:0] ld,
                                              logic [gds_pkg::MonW-1:0] lm,
                                              logic [gds_pkg::YearW-1:0] ly,
                                              logic signed [gds_pkg::CountW-1:0] cnt);
    int        n;
    int        y;
    int        m;
    int        r;
    int        doy;
    int        jan1;
    bit        refused;
    date_rpt_t rpt;
    refused = 1'b0;
    if (cmd == gds_pkg::CmdLoad) begin
      if (ly >= gds_pkg::MinYear && ly <= gds_pkg::MaxYear && lm >= 1 && lm <= 12 &&
          ld >= 1 && ld <= month_days(lm, ly)) begin
        cal_day   = ld;
        cal_month = lm;
        cal_year  = ly;
      end else begin
        refused = 1'b1;
      end
    end else begin
      n = days_to_jan1(cal_year) + year_day(cal_day, cal_month, cal_year) - 1 + int'(cnt);
      if (n < 0 || n >= days_to_jan1(int'(gds_pkg::MaxYear) + 1)) begin
        refused = 1'b1;
      end else begin
        y = n / 366 + 1;
        while (days_to_jan1(y + 1) <= n) y++;
        r = n - days_to_jan1(y);
        m = 1;
        while (m < 12 && r >= month_days(m, y)) begin
          r -= month_days(m, y);
          m++;
        end
        cal_year  = y;
        cal_month = m;
        cal_day   = r + 1;
      end
    end
    doy  = year_day(cal_day, cal_month, cal_year);
    jan1 = day_of_week(1, 1, cal_year);
    rpt.day   = gds_pkg::DayW'(cal_day);
    rpt.month = gds_pkg::MonW'(cal_month);
    rpt.year  = gds_pkg::YearW'(cal_year);
    rpt.wday  = gds_pkg::WdayW'(day_of_week(cal_day, cal_month, cal_year));
    rpt.doy   = gds_pkg::DoyW'(doy);
    rpt.week  = gds_pkg::WeekW'((doy - 1 + jan1) / 7 + 1);
    rpt.qtr   = gds_pkg::QtrW'((cal_month - 1) / 3 + 1);
    rpt.leap  = has_feb29(cal_year);
    rpt.rej   = refused;
    return rpt;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) log_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Outputs are sampled at the rising edge; the block updates them by NBA after it.
  always @(posedge clk) begin
    date_rpt_t want;
    if (!rst && date_bus.valid && date_bus.ready) begin
      if (dates_due.size() == 0) begin
        log_mismatch("result beat with no command outstanding");
      end else begin
        want = dates_due.pop_front();
        check_field("out_day",      date_bus.out_day,      want.day);
        check_field("out_month",    date_bus.out_month,    want.month);
        check_field("out_year",     date_bus.out_year,     want.year);
        check_field("weekday",      date_bus.weekday,      want.wday);
        check_field("day_of_year",  date_bus.day_of_year,  want.doy);
        check_field("week_of_year", date_bus.week_of_year, want.week);
        check_field("quarter",      date_bus.quarter,      want.qtr);
        check_field("is_leap",      date_bus.is_leap,      want.leap);
        check_field("rejected",     date_bus.rejected,     want.rej);
      end
    end
  end

  // Receiver back-pressure: ready drops about one cycle in six, never in the steady stretch.
  initial begin
    date_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      date_bus.ready <= steady_run || ($urandom_range(99) >= IdlePercent);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // valid is only ever assigned once per falling edge.
  task automatic send_command(logic cmd, logic [gds_pkg::DayW-1:0] ld,
                              logic [gds_pkg::MonW-1:0] lm, logic [gds_pkg::YearW-1:0] ly,
                              logic signed [gds_pkg::CountW-1:0] cnt,
                              bit pinned, date_rpt_t pinned_rpt);
    date_rpt_t rpt;
    while (!steady_run && $urandom_range(99) < IdlePercent) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= cmd;
    cmd_bus.load_day   <= ld;
    cmd_bus.load_month <= lm;
    cmd_bus.load_year  <= ly;
    cmd_bus.day_count  <= cnt;
    do @(posedge clk); while (!cmd_bus.ready);
    // Predictor runs for every beat so its calendar tracks the block,
    // even where the row carries a typed-in result.
    rpt = step_calendar(cmd, ld, lm, ly, cnt);
    dates_due.push_back(pinned ? pinned_rpt : rpt);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every outstanding result beat has come back.
  task automatic wait_for_reports();
    cmd_bus.valid <= 1'b0;
    while (dates_due.size() != 0) @(negedge clk);
  endtask

  function automatic void directed_row(logic cmd, int d, int m, int y, int cnt,
                                       bit pinned = 1'b0, date_rpt_t want = '0);
    plan_row_t row;
    row.cmd    = cmd;
    row.day    = gds_pkg::DayW'(d);
    row.month  = gds_pkg::MonW'(m);
    row.year   = gds_pkg::YearW'(y);
    row.count  = gds_pkg::CountW'(cnt);
    row.pinned = pinned;
    row.want   = want;
    plan.push_back(row);
  endfunction

  function automatic date_rpt_t refused(date_rpt_t rpt);
    rpt.rej = 1'b1;
    return rpt;
  endfunction

  initial begin
    logic                              cmd;
    logic [gds_pkg::DayW-1:0]          ld;
    logic [gds_pkg::MonW-1:0]          lm;
    logic [gds_pkg::YearW-1:0]         ly;
    logic signed [gds_pkg::CountW-1:0] cnt;
    int                                y;
    int                                m;

    rst                = 1'b1;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = gds_pkg::CmdLoad;
    cmd_bus.load_day   = '0;
    cmd_bus.load_month = '0;
    cmd_bus.load_year  = '0;
    cmd_bus.day_count  = '0;
    cal_day            = gds_pkg::ResetDay;
    cal_month          = gds_pkg::ResetMonth;
    cal_year           = gds_pkg::ResetYear;

    // Directed table: extremes, both commands, every reject path, leap corners.
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,      0, 1, ResetRpt);   // date after reset
    directed_row(gds_pkg::CmdLoad, 31, 12,  9999,      0, 1, LastDayRpt); // top of range
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,      1, 1, refused(LastDayRpt));
    directed_row(gds_pkg::CmdLoad,  1,  1,     1,      0, 1, FirstDayRpt); // bottom of range
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,     -1, 1, refused(FirstDayRpt));
    directed_row(gds_pkg::CmdAdd,  31, 15, 16383, -32768, 1, refused(FirstDayRpt));
    directed_row(gds_pkg::CmdLoad,  1,  1,     0,      0, 1, refused(FirstDayRpt)); // year 0
    directed_row(gds_pkg::CmdLoad,  1,  0,  2000,      0, 1, refused(FirstDayRpt)); // month 0
    directed_row(gds_pkg::CmdLoad,  1, 13,  2000,      0, 1, refused(FirstDayRpt));
    directed_row(gds_pkg::CmdLoad, 31, 15, 16383,     -1, 1, refused(FirstDayRpt)); // all ones
    directed_row(gds_pkg::CmdLoad,  0,  6,  2000,      0, 1, refused(FirstDayRpt)); // day 0
    // 31st of a 30-day month
    directed_row(gds_pkg::CmdLoad, 31,  4,  2023,      0, 1, refused(FirstDayRpt));
    // century, not leap
    directed_row(gds_pkg::CmdLoad, 29,  2,  1900,      0, 1, refused(FirstDayRpt));
    // past last year
    directed_row(gds_pkg::CmdLoad,  1,  1, 10000,      0, 1, refused(FirstDayRpt));
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,  32767);   // largest forward add
    directed_row(gds_pkg::CmdLoad, 29,  2,  2000,      0);   // leap by 400
    directed_row(gds_pkg::CmdLoad, 29,  2,  2100,      0);   // refused, not by 400
    directed_row(gds_pkg::CmdLoad, 31, 12,  2000,      0);   // week 54
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,      1);   // year rollover
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,     -1);   // year borrow
    directed_row(gds_pkg::CmdAdd,   0,  0,     0, -32768);   // largest backward add
    directed_row(gds_pkg::CmdLoad,  1,  1,  9999,      0);
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,    364);   // lands on last day
    directed_row(gds_pkg::CmdLoad, 28,  2,  2024,      0);
    directed_row(gds_pkg::CmdAdd,   0,  0,     0,      1);   // into Feb 29

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      send_command(plan[i].cmd, plan[i].day, plan[i].month, plan[i].year, plan[i].count,
                   plan[i].pinned, plan[i].want);
    end
    wait_for_reports();
    @(negedge clk);

    // Random part: mostly well-formed loads and adds, some raw-bit loads.
    for (int i = 0; i < RandomBeats; i++) begin
      steady_run = (i >= 200 && i < 300);
      if (i == 100 || i == 350) begin
        wait_for_reports();
        @(negedge clk);
      end
      // Unused fields still carry random bits.
      ld  = gds_pkg::DayW'($urandom);
      lm  = gds_pkg::MonW'($urandom);
      ly  = gds_pkg::YearW'($urandom);
      cnt = gds_pkg::CountW'($urandom);
      if ($urandom_range(99) < 30) begin
        cmd = gds_pkg::CmdLoad;
        if ($urandom_range(99) < 85) begin
          // Valid date, biased toward both ends of the year range.
          case ($urandom_range(9))
            0:       y = $urandom_range(3, 1);
            1:       y = $urandom_range(9999, 9997);
            default: y = $urandom_range(9999, 1);
          endcase
          m  = $urandom_range(12, 1);
          ld = gds_pkg::DayW'($urandom_range(month_days(m, y), 1));
          lm = gds_pkg::MonW'(m);
          ly = gds_pkg::YearW'(y);
        end
      end else begin
        cmd = gds_pkg::CmdAdd;
        // Small counts keep the walk short; full-width counts hit range limits.
        case ($urandom_range(19))
          0, 1, 2, 3:    cnt = cnt;
          4, 5, 6, 7, 8: cnt = gds_pkg::CountW'(int'($urandom_range(10000)) - 5000);
          default:       cnt = gds_pkg::CountW'(int'($urandom_range(800)) - 400);
        endcase
      end
      send_command(cmd, ld, lm, ly, cnt, 1'b0, '0);
    end
    steady_run = 1'b0;

    wait_for_reports();
    // Let any stray beat surface before closing.
    repeat (SettleCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (every add at full walk length).
  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gds_pkg.sv
rtl/gds_chan_if.sv
rtl/gds_ctrl.sv
rtl/gds_datapath.sv
rtl/gregorian_date_stepper.sv
tb/testbench.sv
